FILE: hw/rtl/rne_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types and constants for the Roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

    localparam int unsigned ValueWidth  = 12;
    localparam int unsigned WeightWidth = 10;
    localparam int unsigned ProgLen     = 13;
    localparam int unsigned PcWidth     = $clog2(ProgLen);
    localparam logic [ValueWidth-1:0] MaxValue = 12'd3999;

    localparam logic [7:0] ChrI = 8'h49;
    localparam logic [7:0] ChrV = 8'h56;
    localparam logic [7:0] ChrX = 8'h58;
    localparam logic [7:0] ChrL = 8'h4C;
    localparam logic [7:0] ChrC = 8'h43;
    localparam logic [7:0] ChrD = 8'h44;
    localparam logic [7:0] ChrM = 8'h4D;
    localparam logic [7:0] ChrNone = 8'h00;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // One microcode step: weight to test, characters to emit.
    typedef struct packed {
        logic [WeightWidth-1:0] weight;
        logic [7:0]             first;
        logic [7:0]             second;
        logic                   has_second;
    } t_uword;

    typedef struct packed {
        logic clear;
        logic advance;
    } t_seq_ctl;

endpackage

FILE: hw/rtl/rne_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_sequencer
// Step counter and microcode ROM holding the descending symbol table.
// ----------------------------------------------------------------------------
module rne_sequencer
    import rne_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_seq_ctl i_ctl,
    output t_uword   o_uword
);

    logic [PcWidth-1:0] r_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else if (i_ctl.clear) begin
            r_pc <= '0;
        end else if (i_ctl.advance) begin
            r_pc <= r_pc + PcWidth'(1);
        end
    end

    // Program: one step per table entry, repeated while the rest covers it.
    always_comb begin
        case (r_pc)
            4'd0:    o_uword = '{10'd1000, ChrM, ChrNone, 1'b0};
            4'd1:    o_uword = '{10'd900,  ChrC, ChrM,    1'b1};
            4'd2:    o_uword = '{10'd500,  ChrD, ChrNone, 1'b0};
            4'd3:    o_uword = '{10'd400,  ChrC, ChrD,    1'b1};
            4'd4:    o_uword = '{10'd100,  ChrC, ChrNone, 1'b0};
            4'd5:    o_uword = '{10'd90,   ChrX, ChrC,    1'b1};
            4'd6:    o_uword = '{10'd50,   ChrL, ChrNone, 1'b0};
            4'd7:    o_uword = '{10'd40,   ChrX, ChrL,    1'b1};
            4'd8:    o_uword = '{10'd10,   ChrX, ChrNone, 1'b0};
            4'd9:    o_uword = '{10'd9,    ChrI, ChrX,    1'b1};
            4'd10:   o_uword = '{10'd5,    ChrV, ChrNone, 1'b0};
            4'd11:   o_uword = '{10'd4,    ChrI, ChrV,    1'b1};
            default: o_uword = '{10'd1,    ChrI, ChrNone, 1'b0};
        endcase
    end

endmodule

FILE: hw/rtl/roman_numeral_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roman_numeral_encoder
// Turns a 12-bit value into its Roman numeral, one ASCII character per word.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis takes one value per word (tdata[11:0]). Master
//   channel m_axis returns the numeral, one character per word, most
//   significant symbol first; tlast marks the final character of a value.
//   A value of zero or above 3999 gives a single word with tdata zero,
//   tuser high and tlast high.
// Operation:
//   A value is loaded, then a microcoded sequencer walks the thirteen-entry
//   symbol table: each cycle either emits one character or steps to the
//   next table entry, but a character waits while the output register
//   holds a word not yet taken. The next value is accepted once the last
//   character sits in the output register; one value is worked on at a
//   time.
// Reset and stall:
//   Reset (synchronous, active low) empties the output register and idles
//   the sequencer. While the receiver holds tready low the output word is
//   held and the sequencer waits before emitting the next character.
// ----------------------------------------------------------------------------
module roman_numeral_encoder
    import rne_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] value, [15:12] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] symbol
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] out_of_range
);

    t_state                r_state, n_state;
    logic [ValueWidth-1:0] r_rest,  n_rest;
    logic                  r_err,   n_err;
    logic                  r_phase, n_phase;   // second character pending

    logic                  r_m_valid;
    logic [7:0]            r_m_sym;
    logic                  r_m_last;
    logic                  r_m_err;

    t_seq_ctl              seq_ctl;
    t_uword                uw;

    logic                  out_free;
    logic                  covers;
    logic [ValueWidth-1:0] rest_sub;
    logic                  emit;
    logic [7:0]            e_sym;
    logic                  e_last;
    logic                  e_err;
    logic [ValueWidth-1:0] in_value;

    rne_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (seq_ctl),
        .o_uword (uw)
    );

    assign in_value = s_axis_tdata[ValueWidth-1:0];
    assign out_free = !r_m_valid || m_axis_tready;
    assign covers   = r_rest >= ValueWidth'(uw.weight);
    assign rest_sub = r_rest - ValueWidth'(uw.weight);

    assign s_axis_tready = (r_state == ST_IDLE);

    // Control state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // Working value and error flag.
    always_ff @(posedge i_clk) begin
        r_rest <= n_rest;
        r_err  <= n_err;
    end

    // Next state, datapath control and character selection.
    always_comb begin
        n_state         = r_state;
        n_rest          = r_rest;
        n_err           = r_err;
        n_phase         = r_phase;
        seq_ctl.clear   = 1'b0;
        seq_ctl.advance = 1'b0;
        emit            = 1'b0;
        e_sym           = ChrNone;
        e_last          = 1'b0;
        e_err           = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_rest        = in_value;
                    n_err         = (in_value == '0) || (in_value > MaxValue);
                    n_phase       = 1'b0;
                    seq_ctl.clear = 1'b1;
                    n_state       = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_err) begin
                    // Out of range: a single flagged word ends the run.
                    if (out_free) begin
                        emit    = 1'b1;
                        e_last  = 1'b1;
                        e_err   = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else if (r_phase) begin
                    // Second half of a subtractive pair; weight already taken off.
                    if (out_free) begin
                        emit    = 1'b1;
                        e_sym   = uw.second;
                        e_last  = (r_rest == '0);
                        n_phase = 1'b0;
                        if (r_rest == '0) begin
                            n_state = ST_IDLE;
                        end
                    end
                end else if (covers) begin
                    // Hold the step while the rest still covers its weight.
                    if (out_free) begin
                        emit   = 1'b1;
                        e_sym  = uw.first;
                        n_rest = rest_sub;
                        if (uw.has_second) begin
                            n_phase = 1'b1;
                        end else begin
                            e_last = (rest_sub == '0);
                            if (rest_sub == '0) begin
                                n_state = ST_IDLE;
                            end
                        end
                    end
                end else begin
                    seq_ctl.advance = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register: load on emit, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_m_sym  <= e_sym;
            r_m_last <= e_last;
            r_m_err  <= e_err;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_sym;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_err;

`ifndef SYNTH
    // An error word is the whole run and carries no character.
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == ChrNone))
        else $error("error word malformed");

    // A character word always carries a numeral symbol.
    a_sym_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata != ChrNone))
        else $error("empty numeral character");

    // After a value is loaded, the input is closed in the following cycle.
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input reopened straight after load");

    // A pending second character only exists inside a valid run.
    a_phase_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_state == ST_RUN) && !r_err)
        else $error("pair half pending outside a valid run");
`endif

endmodule
